>>> rtl/ajpd_pkg.sv
`timescale 1ns / 1ps

package ajpd_pkg;

   localparam int unsigned CountWidth    = 8;
   localparam int unsigned FloatRunWidth = 7;
   localparam logic [FloatRunWidth-1:0] FloatRunMax  = 7'd100;
   localparam logic [FloatRunWidth-1:0] FloatRunSure = 7'd5;

   typedef enum logic [2:0] {
      MODE_RELEASE    = 3'd0,
      MODE_ALLDOWN    = 3'd1,
      MODE_HEADPHONES = 3'd2,
      MODE_BUZZER     = 3'd3,
      MODE_SERIAL     = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      PROBE_NONE  = 2'd0,
      PROBE_SENSE = 2'd1,
      PROBE_PULSE = 2'd2
   } probe_type;

   typedef enum logic {
      CMD_TICK  = 1'b0,
      CMD_FORCE = 1'b1
   } cmd_type;

   typedef struct packed {
      logic      pull_up;
      probe_type probe;
   } probe_sel_type;

   typedef struct packed {
      mode_type      jack_mode;
      logic          headphone_enable;
      logic          buzzer_enable;
      logic          power_enable;
      logic          serial_start;
      logic          serial_stop;
      logic          mode_changed;
      probe_sel_type next;
   } result_type;

   function automatic probe_sel_type probe_of(input mode_type mode, input logic forced,
                                              input logic pull_up, input logic tick_zero);
      probe_sel_type sel;
      sel.pull_up = pull_up;
      sel.probe   = PROBE_NONE;
      if (!forced) begin
         if (mode == MODE_HEADPHONES) begin
            sel.pull_up = ~pull_up;
            sel.probe   = PROBE_SENSE;
         end else if ((mode == MODE_ALLDOWN || mode == MODE_BUZZER) && tick_zero) begin
            sel.pull_up = 1'b0;
            sel.probe   = PROBE_PULSE;
         end else if (mode == MODE_SERIAL && tick_zero) begin
            sel.pull_up = 1'b0;
            sel.probe   = PROBE_SENSE;
         end
      end
      return sel;
   endfunction

endpackage

>>> rtl/audio_jack_plug_detector.sv
`timescale 1ns / 1ps

// Jack plug detector.
// Request channel (req_*): one request per tick. A tick request carries the
// sense reading for the test announced on the previous response and the mid
// contact sample; a force request pins the mode to req_target_state, or
// releases it when the target is zero; a target above 4 is ignored.
// Response channel (rsp_*): exactly one response per request, in order, with
// the mode, the enables, the change pulses and the test to make on the next
// tick (pull and probe).
// The response is registered (the skid register takes it while rsp stalls).
// Throughput is one request per cycle while req_ready is high, set by the
// single register stage that updates the window counters and the mode.
// A two-entry output buffer (response register plus skid register) lets one
// further request be taken while a response waits; req_ready drops only while
// both entries are full, and rises again as soon as the receiver takes one.
// Reset selects all-down mode, not forced, pull down, and clears the window
// and float counters; the first tick then makes a pulsed test with pull down.

module audio_jack_plug_detector #(
   parameter int unsigned WINDOW = 200
) (
   input  logic clock,
   input  logic reset,

   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_cmd,
   input  logic [2:0] req_target_state,
   input  logic       req_sense_level,
   input  logic       req_mid_low,

   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_jack_mode,
   output logic       rsp_headphone_enable,
   output logic       rsp_buzzer_enable,
   output logic       rsp_power_enable,
   output logic       rsp_serial_start,
   output logic       rsp_serial_stop,
   output logic       rsp_mode_changed,
   output logic       rsp_next_pull_up,
   output logic [1:0] rsp_next_probe
);

   import ajpd_pkg::*;

   localparam logic [CountWidth-1:0] WindowCount = CountWidth'(WINDOW);

   mode_type                 mode_ff, mode_in;
   mode_type                 forced_ff, forced_in;
   logic                     pull_up_ff, pull_up_in;
   logic [CountWidth-1:0]    tick_ff, tick_in;
   logic [CountWidth-1:0]    low_ff, low_in;
   logic [CountWidth-1:0]    fail_ff, fail_in;
   logic [FloatRunWidth-1:0] float_ff, float_in;

   result_type rsp_ff, skid_ff, result;
   logic       rsp_valid_ff, skid_valid_ff;
   logic       accept;
   logic       out_free;

   probe_sel_type cur_probe;

   assign req_ready = ~skid_valid_ff;
   assign accept    = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign cur_probe = probe_of(mode_ff, forced_ff != MODE_RELEASE, pull_up_ff, tick_ff == '0);

   always_comb begin
      mode_in   = mode_ff;
      forced_in = forced_ff;
      pull_up_in = pull_up_ff;
      tick_in   = tick_ff;
      low_in    = low_ff;
      fail_in   = fail_ff;
      float_in  = float_ff;
      if (req_cmd == CMD_FORCE) begin
         if (req_target_state <= MODE_SERIAL) begin
            forced_in = mode_type'(req_target_state);
            if (req_target_state != MODE_RELEASE) begin
               mode_in = mode_type'(req_target_state);
            end
         end
      end else if (forced_ff == MODE_RELEASE) begin
         if (cur_probe.probe != PROBE_NONE) begin
            pull_up_in = cur_probe.pull_up;
            if (req_sense_level != cur_probe.pull_up && fail_ff != '1) begin
               fail_in = fail_ff + 1'b1;
            end
         end
         if (mode_ff != MODE_SERIAL && req_mid_low && low_ff != '1) begin
            low_in = low_ff + 1'b1;
         end
         if (tick_ff != '1) begin
            tick_in = tick_ff + 1'b1;
         end
         if (tick_in >= WindowCount) begin
            if (float_ff != '0) begin
               if (low_in == WindowCount) begin
                  mode_in = MODE_HEADPHONES;
               end else if (float_ff > FloatRunSure) begin
                  mode_in = MODE_SERIAL;
               end
            end else if (!(mode_ff == MODE_ALLDOWN && fail_in == '0)) begin
               mode_in = MODE_BUZZER;
            end
            if (fail_in == '0) begin
               if (float_ff < FloatRunMax) begin
                  float_in = float_ff + 1'b1;
               end
            end else begin
               float_in = '0;
            end
            tick_in = '0;
            low_in  = '0;
            fail_in = '0;
         end
      end
   end

   always_comb begin
      result.jack_mode        = mode_in;
      result.headphone_enable = mode_in == MODE_HEADPHONES;
      result.buzzer_enable    = mode_in == MODE_BUZZER || mode_in == MODE_SERIAL;
      result.power_enable     = mode_in == MODE_SERIAL;
      result.mode_changed     = mode_in != mode_ff;
      result.serial_start     = mode_in != mode_ff && mode_in == MODE_SERIAL;
      result.serial_stop      = mode_in != mode_ff && mode_ff == MODE_SERIAL;
      result.next             = probe_of(mode_in, forced_in != MODE_RELEASE, pull_up_in,
                                         tick_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_ALLDOWN;
         forced_ff  <= MODE_RELEASE;
         pull_up_ff <= 1'b0;
         tick_ff    <= '0;
         low_ff     <= '0;
         fail_ff    <= '0;
         float_ff   <= '0;
      end else if (accept) begin
         mode_ff    <= mode_in;
         forced_ff  <= forced_in;
         pull_up_ff <= pull_up_in;
         tick_ff    <= tick_in;
         low_ff     <= low_in;
         fail_ff    <= fail_in;
         float_ff   <= float_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff  <= skid_valid_ff | accept;
         skid_valid_ff <= 1'b0;
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_ff <= skid_valid_ff ? skid_ff : result;
      end else if (accept) begin
         skid_ff <= result;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_jack_mode        = rsp_ff.jack_mode;
   assign rsp_headphone_enable = rsp_ff.headphone_enable;
   assign rsp_buzzer_enable    = rsp_ff.buzzer_enable;
   assign rsp_power_enable     = rsp_ff.power_enable;
   assign rsp_serial_start     = rsp_ff.serial_start;
   assign rsp_serial_stop      = rsp_ff.serial_stop;
   assign rsp_mode_changed     = rsp_ff.mode_changed;
   assign rsp_next_pull_up     = rsp_ff.next.pull_up;
   assign rsp_next_probe       = rsp_ff.next.probe;

   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held without a response in front");

   a_start_stop_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_serial_start && rsp_serial_stop))
      else $error("serial start and stop raised together");

   a_power_needs_buzzer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_power_enable |-> rsp_buzzer_enable && !rsp_headphone_enable)
      else $error("power enable outside buzzer-serial mode");

   a_forced_tick_holds: assert property (@(posedge clock) disable iff (reset)
      accept && req_cmd == CMD_TICK && forced_ff != MODE_RELEASE
      |=> $stable(tick_ff) && $stable(mode_ff) && $stable(float_ff))
      else $error("forced tick changed detector state");

endmodule
